[rtl/lru_pr_pkg.sv]
`timescale 1ns / 1ps
// lru_pr_pkg: shared types and fixed widths for the lru page replacement block
// no dependencies

package lru_pr_pkg;

    localparam int PAGE_W      = 16;
    localparam int FRAME_IDX_W = 4;
    localparam int CFG_W       = 5;
    localparam int COUNT_W     = 16;

    localparam logic [COUNT_W-1:0] FAULT_MAX = {COUNT_W{1'b1}};

    // outcome of one page reference, from the frame table to the top level
    typedef struct packed {
        logic                   fault;
        logic [FRAME_IDX_W-1:0] frame_index;
        logic                   evicted_valid;
        logic [PAGE_W-1:0]      evicted_page;
    } t_ref_result;

endpackage

[rtl/lru_pr_frames.sv]
`timescale 1ns / 1ps
// lru_pr_frames: frame table with valid bits, recency ranks, lookup and victim choice
// depends on lru_pr_pkg

module lru_pr_frames
    import lru_pr_pkg::*;
#(
    parameter int NFRAMES   = 16,
    parameter int PAGE_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_fire,
    input  logic [PAGE_W-1:0] i_page,
    output t_ref_result       o_result
);

    localparam int PW = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
    localparam int IW = (NFRAMES > 1) ? $clog2(NFRAMES) : 1;
    localparam int RW = IW;
    localparam int CW = $clog2(NFRAMES + 1);
    localparam logic [CW-1:0] NF_C     = CW'(NFRAMES);
    localparam logic [CW-1:0] RESET_FC = CW'((NFRAMES < 16) ? NFRAMES : 16);

    logic [PW-1:0]      r_page [NFRAMES];
    logic [NFRAMES-1:0] r_valid, n_valid;
    logic [RW-1:0]      r_rank [NFRAMES];
    logic [RW-1:0]      n_rank [NFRAMES];
    logic [CW-1:0]      r_fc, n_fc;

    logic [PW-1:0]      page;
    logic [NFRAMES-1:0] active, match, empty, victim;
    logic               hit, any_empty;
    logic [IW-1:0]      hit_idx, empty_idx, victim_idx, f;
    logic [RW-1:0]      rank_f, oldest;

    assign page   = i_page[PW-1:0];
    assign oldest = RW'(r_fc - CW'(1));

    always_comb begin
        for (int i = 0; i < NFRAMES; i++) begin
            active[i] = r_fc > CW'(i);
            match[i]  = active[i] && r_valid[i] && (r_page[i] == page);
            empty[i]  = active[i] && !r_valid[i];
            // ranks of active frames form a permutation once all are filled
            victim[i] = active[i] && (r_rank[i] == oldest);
        end
    end

    always_comb begin
        hit_idx    = '0;
        empty_idx  = '0;
        victim_idx = '0;
        for (int i = NFRAMES - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_idx = IW'(i);
            end
            if (empty[i]) begin
                empty_idx = IW'(i);
            end
            if (victim[i]) begin
                victim_idx = IW'(i);
            end
        end
    end

    assign hit       = |match;
    assign any_empty = |empty;
    assign f         = hit ? hit_idx : (any_empty ? empty_idx : victim_idx);
    assign rank_f    = r_rank[f];

    always_comb begin
        o_result.fault         = !hit;
        o_result.frame_index   = FRAME_IDX_W'(f);
        o_result.evicted_valid = !hit && !any_empty;
        o_result.evicted_page  = (!hit && !any_empty) ? PAGE_W'(r_page[f]) : '0;
    end

    always_comb begin
        n_fc    = r_fc;
        n_valid = r_valid;
        n_rank  = r_rank;
        if (i_cfg_we) begin
            if (i_cfg_data == '0) begin
                n_fc = CW'(1);
            end else if (int'(i_cfg_data) > NFRAMES) begin
                n_fc = NF_C;
            end else begin
                n_fc = CW'(i_cfg_data);
            end
            n_valid = '0;
            for (int i = 0; i < NFRAMES; i++) begin
                n_rank[i] = '0;
            end
        end else if (i_fire) begin
            for (int i = 0; i < NFRAMES; i++) begin
                if ((IW'(i) != f) && r_valid[i] && active[i]
                    && (!hit || (r_rank[i] < rank_f))) begin
                    n_rank[i] = r_rank[i] + RW'(1);
                end
            end
            n_rank[f]  = '0;
            n_valid[f] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fc    <= RESET_FC;
            r_valid <= '0;
            for (int i = 0; i < NFRAMES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            r_fc    <= n_fc;
            r_valid <= n_valid;
            r_rank  <= n_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_cfg_we && i_fire && !hit) begin
            r_page[f] <= page;
        end
    end

endmodule

[rtl/lru_page_replacement_top.sv]
`timescale 1ns / 1ps
// lru_page_replacement_top: input register, frame table, fault counter, result register
// depends on lru_pr_pkg and lru_pr_frames
//
//   channel  | valid       | stall        | data
//   ---------+-------------+--------------+------------------------------------------
//   in       | i_in_valid  | o_in_stall   | i_page_number
//   out      | o_out_valid | i_out_stall  | o_fault, o_frame_index, o_evicted_valid,
//            |             |              | o_evicted_page, o_fault_count
//   cfg      | i_cfg_we    | -            | i_cfg_data
//
// one word per cycle unless the result stalls; words pass input, then result register
// lookup, victim choice and rank update are combinational from the input register
// synchronous active-low reset empties all frames and clears the fault count
// a stalled result holds; the input register takes at most one more word, then stalls

module lru_page_replacement_top
    import lru_pr_pkg::*;
#(
    parameter int NFRAMES   = 16,
    parameter int PAGE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_W-1:0]       i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [PAGE_W-1:0]      i_page_number,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_fault,
    output logic [FRAME_IDX_W-1:0] o_frame_index,
    output logic                   o_evicted_valid,
    output logic [PAGE_W-1:0]      o_evicted_page,
    output logic [COUNT_W-1:0]     o_fault_count
);

    logic               r_in_valid;
    logic [PAGE_W-1:0]  r_page;
    logic               r_out_valid;
    t_ref_result        r_result;
    logic [COUNT_W-1:0] r_fault_total, n_fault_total;

    logic        advance, accept_in;
    t_ref_result result;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign accept_in  = i_in_valid && !o_in_stall;

    lru_pr_frames #(
        .NFRAMES   (NFRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_frames (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_fire     (advance),
        .i_page     (r_page),
        .o_result   (result)
    );

    always_comb begin
        n_fault_total = r_fault_total;
        if (advance && result.fault && (r_fault_total != FAULT_MAX)) begin
            n_fault_total = r_fault_total + COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_fault_total <= '0;
        end else begin
            r_fault_total <= n_fault_total;
            if (accept_in) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_page <= i_page_number;
        end
        if (advance) begin
            r_result <= result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_fault         = r_result.fault;
    assign o_frame_index   = r_result.frame_index;
    assign o_evicted_valid = r_result.evicted_valid;
    assign o_evicted_page  = r_result.evicted_page;
    assign o_fault_count   = r_fault_total;

endmodule

[test/lru_pr_checker.sv]
`timescale 1ns / 1ps
// lru_pr_checker: watches the page and result channels of lru_page_replacement_top
// keeps its own lru frame table, predicts every result word and compares them in order
// depends on lru_pr_pkg

module lru_pr_checker
    import lru_pr_pkg::*;
#(
    parameter int NFRAMES = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_W-1:0]       i_cfg_data,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  logic [PAGE_W-1:0]      i_page_number,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic                   i_fault,
    input  logic [FRAME_IDX_W-1:0] i_frame_index,
    input  logic                   i_evicted_valid,
    input  logic [PAGE_W-1:0]      i_evicted_page,
    input  logic [COUNT_W-1:0]     i_fault_count,
    output int                     o_words_pending,
    output int                     o_fail_count
);

    typedef struct packed {
        t_ref_result        res;
        logic [COUNT_W-1:0] fault_count;
    } t_outcome;

    localparam int REPORT_MAX = 10;

    logic [PAGE_W-1:0]      held_page  [NFRAMES];
    logic                   held_valid [NFRAMES];
    logic [FRAME_IDX_W-1:0] age        [NFRAMES];
    logic [COUNT_W-1:0]     fault_tally;
    int unsigned            active_frames;
    t_outcome               outcome_q[$];
    int                     mismatches = 0;

    assign o_fail_count = mismatches;

    task automatic flush_table();
        int i;
        for (i = 0; i < NFRAMES; i++) begin
            held_page[i]  = '0;
            held_valid[i] = 1'b0;
            age[i]        = '0;
        end
    endtask

    // age every younger valid frame, then frame f becomes the newest
    task automatic make_recent(input int unsigned f, input int unsigned limit);
        int unsigned i;
        for (i = 0; i < active_frames; i++) begin
            if (i != f && held_valid[i] && age[i] < limit) begin
                age[i] = age[i] + 1'b1;
            end
        end
        age[f] = '0;
    endtask

    task automatic reference_page(input logic [PAGE_W-1:0] page, output t_outcome o);
        int unsigned i;
        int unsigned f;
        int unsigned best;
        bit          hit;
        bit          empty;
        hit   = 1'b0;
        empty = 1'b0;
        f     = 0;
        o     = '0;
        for (i = 0; i < active_frames; i++) begin
            if (!hit && held_valid[i] && held_page[i] == page) begin
                hit = 1'b1;
                f   = i;
            end
        end
        if (hit) begin
            make_recent(f, age[f]);
        end else begin
            for (i = 0; i < active_frames; i++) begin
                if (!empty && !held_valid[i]) begin
                    empty = 1'b1;
                    f     = i;
                end
            end
            if (!empty) begin
                // oldest frame, lowest index on a tie
                best = 0;
                f    = 0;
                for (i = 0; i < active_frames; i++) begin
                    if (age[i] > best) begin
                        best = age[i];
                        f    = i;
                    end
                end
                o.res.evicted_valid = 1'b1;
                o.res.evicted_page  = held_page[f];
            end
            held_page[f]  = page;
            held_valid[f] = 1'b1;
            make_recent(f, 32'hFFFF_FFFF);
            if (fault_tally != FAULT_MAX) begin
                fault_tally = fault_tally + 1'b1;
            end
        end
        o.res.fault       = !hit;
        o.res.frame_index = f[FRAME_IDX_W-1:0];
        o.fault_count     = fault_tally;
    endtask

    always @(posedge i_clk) begin : watch
        t_outcome want;
        t_outcome seen;
        if (!i_rst_n) begin
            flush_table();
            fault_tally   = '0;
            active_frames = NFRAMES;
            outcome_q.delete();
            o_words_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_data == 0) begin
                    active_frames = 1;
                end else if (i_cfg_data > NFRAMES) begin
                    active_frames = NFRAMES;
                end else begin
                    active_frames = int'(i_cfg_data);
                end
                flush_table();
            end
            if (i_out_valid && !i_out_stall) begin
                seen = {i_fault, i_frame_index, i_evicted_valid, i_evicted_page,
                        i_fault_count};
                if (outcome_q.size() == 0) begin
                    if (mismatches < REPORT_MAX) begin
                        $display("%t: result word with nothing expected: fault=%0b frame=%0d",
                                 $realtime, seen.res.fault, seen.res.frame_index);
                    end
                    mismatches++;
                end else begin
                    want = outcome_q.pop_front();
                    if (want.res.fault !== seen.res.fault
                            || want.res.frame_index !== seen.res.frame_index
                            || want.res.evicted_valid !== seen.res.evicted_valid
                            || want.res.evicted_page !== seen.res.evicted_page
                            || want.fault_count !== seen.fault_count) begin
                        if (mismatches < REPORT_MAX) begin
                            $display("%t: mismatch fault/frame/evicted/page/count", $realtime);
                            $display("    expected %0b %0d %0b %h %0d", want.res.fault,
                                     want.res.frame_index, want.res.evicted_valid,
                                     want.res.evicted_page, want.fault_count);
                            $display("    actual   %0b %0d %0b %h %0d", seen.res.fault,
                                     seen.res.frame_index, seen.res.evicted_valid,
                                     seen.res.evicted_page, seen.fault_count);
                        end
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                reference_page(i_page_number, want);
                outcome_q.push_back(want);
            end
            o_words_pending <= outcome_q.size();
        end
    end

endmodule

[test/tb_lru_page_replacement_top.sv]
`timescale 1ns / 1ps
// tb_lru_page_replacement_top: drives page references, frame count writes and result stalls
// depends on lru_pr_pkg, lru_page_replacement_top and lru_pr_checker

module tb_lru_page_replacement_top;
    import lru_pr_pkg::*;

    localparam int N_FRAMES     = 16;
    localparam int QUIET_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 8;
    localparam int RANDOM_ITEMS = 1350;

    logic                   i_clk;
    logic                   i_rst_n        = 1'b0;
    logic                   i_cfg_we       = 1'b0;
    logic [CFG_W-1:0]       i_cfg_data     = '0;
    logic                   i_in_valid     = 1'b0;
    logic                   o_in_stall;
    logic [PAGE_W-1:0]      i_page_number  = '0;
    logic                   o_out_valid;
    logic                   i_out_stall    = 1'b0;
    logic                   o_fault;
    logic [FRAME_IDX_W-1:0] o_frame_index;
    logic                   o_evicted_valid;
    logic [PAGE_W-1:0]      o_evicted_page;
    logic [COUNT_W-1:0]     o_fault_count;

    int          words_pending;
    int          fail_count;
    int unsigned out_hold     = 0;
    int unsigned quiet_cycles = 0;
    int unsigned pages_sent   = 0;
    int unsigned cfg_writes   = 0;
    int unsigned table_size   = N_FRAMES;
    bit          tx_quiet     = 1'b0;
    bit          rx_quiet     = 1'b0;

    lru_page_replacement_top #(
        .NFRAMES   (N_FRAMES),
        .PAGE_BITS (PAGE_W)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_page_number   (i_page_number),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_fault         (o_fault),
        .o_frame_index   (o_frame_index),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_fault_count   (o_fault_count)
    );

    lru_pr_checker #(
        .NFRAMES (N_FRAMES)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_page_number   (i_page_number),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_fault         (o_fault),
        .i_frame_index   (o_frame_index),
        .i_evicted_valid (o_evicted_valid),
        .i_evicted_page  (o_evicted_page),
        .i_fault_count   (o_fault_count),
        .o_words_pending (words_pending),
        .o_fail_count    (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side: unless rx_quiet is set, hold off a random number of cycles after every word taken
    always @(posedge i_clk) begin : result_side
        int unsigned hold;
        if (o_out_valid && !i_out_stall) begin
            hold = rx_quiet ? 0 : $urandom_range(0, 7);
            out_hold    <= hold;
            i_out_stall <= (hold != 0);
        end else if (out_hold != 0) begin
            out_hold    <= out_hold - 1;
            i_out_stall <= (out_hold > 1);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no progress for %0d cycles", QUIET_LIMIT);
            $display("[lru_page_replacement_top] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_page(input logic [PAGE_W-1:0] page);
        int unsigned gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_page_number <= page;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pages_sent++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (words_pending != 0) @(posedge i_clk);
    endtask

    task automatic write_frames(input logic [CFG_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        table_size = (value == 0) ? 1 : ((value > N_FRAMES) ? N_FRAMES : int'(value));
        cfg_writes++;
    endtask

    // mostly a working set near the table size so hits and lru evictions dominate
    task automatic run_phase(input int unsigned count);
        logic [PAGE_W-1:0] pool [N_FRAMES + 4];
        logic [PAGE_W-1:0] page;
        int unsigned       span;
        int unsigned       pick;
        int unsigned       k;
        span = $urandom_range(1, table_size + 4);
        for (k = 0; k < span; k++) begin
            if ($urandom_range(0, 3) == 0) begin
                pool[k] = k[0] ? PAGE_W'(16'hFFFF - k) : PAGE_W'(k);
            end else begin
                pool[k] = PAGE_W'($urandom());
            end
        end
        for (k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
                page = pool[$urandom_range(0, span - 1)];
            end else if (pick < 95) begin
                page = PAGE_W'($urandom());
            end else begin
                page = pick[0] ? '1 : '0;
            end
            send_page(page);
            if ($urandom_range(0, 63) == 0) begin
                settle();
            end
        end
    endtask

    initial begin : stimulus
        logic [CFG_W-1:0] cfg_pick;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full table after reset
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'h0000);
        send_page(16'h5555);
        send_page(16'hAAAA);
        send_page(16'hFFFF);
        // zero frames counts as one
        settle();
        write_frames(5'd0);
        send_page(16'h1234);
        send_page(16'h1234);
        send_page(16'h4321);
        send_page(16'h1234);
        // above range counts as full, table flushed
        settle();
        write_frames(5'd31);
        send_page(16'h4321);
        // three frames: fill, hit, lru eviction
        settle();
        write_frames(5'd3);
        send_page(16'h0001);
        send_page(16'h0002);
        send_page(16'h0003);
        send_page(16'h0001);
        send_page(16'h0004);
        send_page(16'h0003);
        send_page(16'h0005);
        settle();
        write_frames(5'd16);
        send_page(16'h0005);

        while (pages_sent < RANDOM_ITEMS) begin
            settle();
            case ($urandom_range(0, 5))
                0:       cfg_pick = 5'd0;
                1:       cfg_pick = 5'd1;
                2:       cfg_pick = 5'd16;
                3:       cfg_pick = 5'd31;
                default: cfg_pick = CFG_W'($urandom_range(0, 31));
            endcase
            write_frames(cfg_pick);
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            run_phase($urandom_range(40, 160));
        end

        settle();
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        write_frames(CFG_W'($urandom_range(2, 15)));
        run_phase(150);
        settle();
        write_frames(5'd16);
        run_phase(100);

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("%0d page references over %0d frame count settings, with random stalls",
                 pages_sent, cfg_writes);
        if (fail_count == 0 && words_pending == 0) begin
            $display("[lru_page_replacement_top] OK");
        end else begin
            $display("%0d mismatched words", fail_count);
            $display("[lru_page_replacement_top] ERROR");
        end
        $finish;
    end

endmodule

[lru_page_replacement_top.f]
rtl/lru_pr_pkg.sv
rtl/lru_pr_frames.sv
rtl/lru_page_replacement_top.sv
test/lru_pr_checker.sv
test/tb_lru_page_replacement_top.sv
